>>> src/odmp_pkg.sv
package odmp_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  localparam logic [8:0] THRESHOLD_RST = 9'd14;

  // stage word handed from front to back
  typedef struct packed {
    logic [7:0]  value;
    logic [13:0] prod;     // value * matrix entry
    logic [2:0]  pos;      // col % 7
    logic [12:0] addr;
  } odmp_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } odmp_qstat_t;

  // 8x8 Bayer matrix, entries 1..64 (row 5 col 0 holds 35)
  function automatic logic [6:0] bayer_entry(input logic [2:0] row, input logic [2:0] col);
    logic [6:0] m;
    case ({row, col})
      6'o00: m = 7'd1;  6'o01: m = 7'd49; 6'o02: m = 7'd13; 6'o03: m = 7'd61;
      6'o04: m = 7'd4;  6'o05: m = 7'd52; 6'o06: m = 7'd16; 6'o07: m = 7'd64;
      6'o10: m = 7'd33; 6'o11: m = 7'd17; 6'o12: m = 7'd45; 6'o13: m = 7'd29;
      6'o14: m = 7'd36; 6'o15: m = 7'd20; 6'o16: m = 7'd48; 6'o17: m = 7'd32;
      6'o20: m = 7'd9;  6'o21: m = 7'd57; 6'o22: m = 7'd5;  6'o23: m = 7'd53;
      6'o24: m = 7'd12; 6'o25: m = 7'd60; 6'o26: m = 7'd8;  6'o27: m = 7'd56;
      6'o30: m = 7'd41; 6'o31: m = 7'd25; 6'o32: m = 7'd37; 6'o33: m = 7'd21;
      6'o34: m = 7'd44; 6'o35: m = 7'd28; 6'o36: m = 7'd40; 6'o37: m = 7'd24;
      6'o40: m = 7'd3;  6'o41: m = 7'd51; 6'o42: m = 7'd15; 6'o43: m = 7'd63;
      6'o44: m = 7'd2;  6'o45: m = 7'd50; 6'o46: m = 7'd14; 6'o47: m = 7'd62;
      6'o50: m = 7'd35; 6'o51: m = 7'd19; 6'o52: m = 7'd47; 6'o53: m = 7'd31;
      6'o54: m = 7'd34; 6'o55: m = 7'd18; 6'o56: m = 7'd46; 6'o57: m = 7'd30;
      6'o60: m = 7'd11; 6'o61: m = 7'd59; 6'o62: m = 7'd7;  6'o63: m = 7'd55;
      6'o64: m = 7'd10; 6'o65: m = 7'd58; 6'o66: m = 7'd6;  6'o67: m = 7'd54;
      6'o70: m = 7'd43; 6'o71: m = 7'd27; 6'o72: m = 7'd39; 6'o73: m = 7'd23;
      6'o74: m = 7'd42; 6'o75: m = 7'd26; 6'o76: m = 7'd38; 6'o77: m = 7'd22;
      default: m = 7'd1;
    endcase
    return m;
  endfunction

endpackage

>>> src/ordered_dither_mono_packer_unit.sv
// A byte-closing word passes the front register, a queue slot and the output register.
// Throughput: one word per cycle while the 4-entry queue has room; it splits front/back stalls.
// Pixels off screen are dropped in the front stage; others at column position 0..5
// only update the bit accumulator, position 6 emits one output word.
// Reset (rst_n low, synchronous) empties the pipeline and queue, clears the
// accumulator and sets the threshold to 14.
module ordered_dither_mono_packer_unit #(
  parameter int unsigned SCREEN_WIDTH  = 280,
  parameter int unsigned SCREEN_HEIGHT = 192
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // pixel_value[7:0], screen_row[15:8], screen_col[24:16], pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // byte_address[12:0], byte_data[19:13], pad
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata
);

  logic [8:0]            threshold_r, threshold_nxt;
  logic                  push, pop;
  odmp_pkg::odmp_entry_t push_entry, pop_entry;
  odmp_pkg::odmp_qstat_t q_stat;
  logic [12:0]           byte_address;
  logic [6:0]            byte_data;

  assign threshold_nxt = cfg_we ? cfg_wdata : threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= odmp_pkg::THRESHOLD_RST;
    end else begin
      threshold_r <= threshold_nxt;
    end
  end

  odmp_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .pixel_value(in_tdata[7:0]),
    .screen_row (in_tdata[15:8]),
    .screen_col (in_tdata[24:16]),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  odmp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .pop_entry (pop_entry),
    .q_stat    (q_stat)
  );

  odmp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .threshold   (threshold_r),
    .q_stat      (q_stat),
    .entry       (pop_entry),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .byte_address(byte_address),
    .byte_data   (byte_data)
  );

  assign out_tdata = {4'b0, byte_data, byte_address};

endmodule

>>> src/odmp_front.sv
module odmp_front #(
  parameter int unsigned SCREEN_WIDTH  = 280,
  parameter int unsigned SCREEN_HEIGHT = 192
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           pixel_value,
  input  logic [7:0]           screen_row,
  input  logic [8:0]           screen_col,
  input  odmp_pkg::odmp_qstat_t q_stat,
  output logic                 push,
  output odmp_pkg::odmp_entry_t push_entry
);

  logic                  f_valid_r, f_valid_nxt;
  odmp_pkg::odmp_entry_t f_entry_r, f_entry_nxt;
  logic                  accept, on_screen, moved;
  logic [15:0]           col_x73;
  logic [6:0]            q0;
  logic [9:0]            q0_x7;
  logic [9:0]            rem0;
  logic [6:0]            col_div7;
  logic [2:0]            col_mod7;
  logic [12:0]           addr;
  logic [6:0]            bayer_m;

  assign moved    = f_valid_r && !q_stat.full;
  assign in_ready = !f_valid_r || !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign on_screen = ({1'b0, screen_col} < 10'(SCREEN_WIDTH)) &&
                     ({1'b0, screen_row} < 9'(SCREEN_HEIGHT));

  assign bayer_m = odmp_pkg::bayer_entry(screen_row[2:0], screen_col[2:0]);

  // col / 7 via 73/512, undershoots by at most one
  always_comb begin
    col_x73  = ({7'b0, screen_col} << 6) + ({7'b0, screen_col} << 3) + {7'b0, screen_col};
    q0       = col_x73[15:9];
    q0_x7    = ({3'b0, q0} << 3) - {3'b0, q0};
    rem0     = {1'b0, screen_col} - q0_x7;
    if (rem0 >= 10'd7) begin
      col_div7 = q0 + 7'd1;
      col_mod7 = 3'(rem0 - 10'd7);
    end else begin
      col_div7 = q0;
      col_mod7 = rem0[2:0];
    end
    addr = {screen_row[2:0], 10'b0} + {3'b0, screen_row[5:3], 7'b0} +
           13'({screen_row[7:6], 5'b0} + {2'b0, screen_row[7:6], 3'b0}) +
           {6'b0, col_div7};
  end

  always_comb begin
    f_entry_nxt       = f_entry_r;
    f_valid_nxt       = moved ? 1'b0 : f_valid_r;
    if (accept && on_screen) begin
      f_valid_nxt       = 1'b1;
      f_entry_nxt.value = pixel_value;
      f_entry_nxt.prod  = {6'b0, pixel_value} * {7'b0, bayer_m};
      f_entry_nxt.pos   = col_mod7;
      f_entry_nxt.addr  = addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
    f_entry_r <= f_entry_nxt;
  end

  assign push       = moved;
  assign push_entry = f_entry_r;

endmodule

>>> src/odmp_queue.sv
module odmp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  odmp_pkg::odmp_entry_t push_entry,
  input  logic                  pop,
  output odmp_pkg::odmp_entry_t pop_entry,
  output odmp_pkg::odmp_qstat_t q_stat
);

  odmp_pkg::odmp_entry_t               slot_r [odmp_pkg::QDEPTH];
  logic [odmp_pkg::QPTR_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [odmp_pkg::QPTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [odmp_pkg::QCNT_W-1:0]         count_r, count_nxt;

  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == odmp_pkg::QCNT_W'(odmp_pkg::QDEPTH));
  assign pop_entry    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

>>> src/odmp_back.sv
module odmp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [8:0]            threshold,
  input  odmp_pkg::odmp_qstat_t q_stat,
  input  odmp_pkg::odmp_entry_t entry,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [12:0]           byte_address,
  output logic [6:0]            byte_data
);

  logic [5:0]  acc_r, acc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [12:0] out_addr_r, out_addr_nxt;
  logic [6:0]  out_data_r, out_data_nxt;
  logic [24:0] prod_x1040;
  logic [8:0]  q0;
  logic [14:0] q0_x63;
  logic [14:0] rem0;
  logic [8:0]  quot;
  logic [9:0]  dith;
  logic        lit, is_last, can_take;

  // prod / 63 via 1040/65536, undershoots by at most one
  always_comb begin
    prod_x1040 = ({11'b0, entry.prod} << 10) + ({11'b0, entry.prod} << 4);
    q0         = prod_x1040[24:16];
    q0_x63     = ({6'b0, q0} << 6) - {6'b0, q0};
    rem0       = {1'b0, entry.prod} - q0_x63;
    quot       = (rem0 >= 15'd63) ? q0 + 9'd1 : q0;
    dith       = {2'b0, entry.value} + {1'b0, quot};
    lit        = (dith >= {1'b0, threshold});
  end

  assign is_last  = (entry.pos == 3'd6);
  assign can_take = !is_last || !out_valid_r || out_ready;
  assign pop      = !q_stat.empty && can_take;

  always_comb begin
    acc_nxt       = acc_r;
    out_valid_nxt = (out_valid_r && !out_ready) ? 1'b1 : 1'b0;
    out_addr_nxt  = out_addr_r;
    out_data_nxt  = out_data_r;
    if (pop) begin
      if (is_last) begin
        out_valid_nxt = 1'b1;
        out_addr_nxt  = entry.addr;
        out_data_nxt  = {lit, acc_r};
      end else begin
        for (int i = 0; i < 6; i++) begin
          if (entry.pos == 3'(i)) begin
            acc_nxt[i] = lit;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_addr_r <= out_addr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid    = out_valid_r;
  assign byte_address = out_addr_r;
  assign byte_data    = out_data_r;

endmodule

>>> src/odmp_checker.sv
module odmp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // held output word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // offered input word stays put until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("input word changed while stalled");

  // reset empties the output stage
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid set after reset");

  // pipeline empty after reset, so input side must be open
  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("in_tready low after reset");

  // byte bit 7 and padding never carried
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:20] == 4'b0)
    else $error("output padding not zero");

endmodule

bind ordered_dither_mono_packer_unit odmp_checker u_odmp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tdata  (in_tdata),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
